// File: rtl/slif_pkg.sv
// Shared types and constants for the stochastic LIF neuron core.
package slif_pkg;

  // Request kinds carried in s_tuser
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_CLAMP = 2'd2;
  localparam logic [1:0] REQ_RESET = 2'd3;

  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_POS  = 2'd1,
    CLAMP_NEG  = 2'd2
  } clamp_mode_t;

  // Register word indexes (byte address = 4 * index)
  localparam logic [2:0] REG_THRESHOLD   = 3'd0;
  localparam logic [2:0] REG_RESET_LEVEL = 3'd1;
  localparam logic [2:0] REG_BIAS        = 3'd2;
  localparam logic [2:0] REG_LEAK        = 3'd3;
  localparam logic [2:0] REG_SPIKE_PROB  = 3'd4;

  // Q1.16 one
  localparam logic [16:0] Q_ONE = 17'h10000;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  localparam logic signed [31:0] THRESHOLD_RST = 32'sd65536;

endpackage

// File: rtl/stochastic_lif_neuron_core.sv
// Top level of the stochastic leaky integrate-and-fire neuron core.
//
// One Q16.16 neuron driven by a word stream. s_tuser carries the request kind
// (tick, add synaptic current, set clamp, model reset); s_tdata carries the
// value and the random sample used by a tick. Every input word yields exactly
// one output word on the m_ side: the spike flag and the membrane after the
// update. Registers (threshold, reset level, bias, leak, spike probability)
// sit on the APB port at byte addresses 0x00..0x10; write them only while the
// core is idle.
// A word accepted on s_ goes through the input register, then the update into
// the result register, which raises m_tvalid. Throughput: one word per cycle
// while the receiver takes results; the membrane, synaptic sum and clamp state
// close their loop through the saturating add, threshold compare and the 32x17
// decay multiply, with no register inside the loop.
// Reset (rst, synchronous) clears membrane, synaptic sum and clamp, loads the
// register reset values and empties both stages. When the receiver stalls,
// the result register holds its word; an empty input register still takes
// one word, and s_tready is low while the input register is full and stalled.
module stochastic_lif_neuron_core
  import slif_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [31:0] value, [47:32] random_sample
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [0] spike, [32:1] membrane, [39:33] zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] threshold;
  logic signed [31:0] reset_level;
  logic signed [31:0] bias;
  logic [16:0]        leak_fraction;
  logic [16:0]        spike_probability;

  logic       cfg_write;
  logic [2:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold         <= THRESHOLD_RST;
      reset_level       <= '0;
      bias              <= '0;
      leak_fraction     <= '0;
      spike_probability <= Q_ONE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THRESHOLD:   threshold         <= pwdata;
        REG_RESET_LEVEL: reset_level       <= pwdata;
        REG_BIAS:        bias              <= pwdata;
        REG_LEAK:        leak_fraction     <= pwdata[16:0];
        REG_SPIKE_PROB:  spike_probability <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_THRESHOLD:   prdata = threshold;
      REG_RESET_LEVEL: prdata = reset_level;
      REG_BIAS:        prdata = bias;
      REG_LEAK:        prdata = {15'd0, leak_fraction};
      REG_SPIKE_PROB:  prdata = {15'd0, spike_probability};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic               p_valid;
  logic [1:0]         p_req;
  logic signed [31:0] p_value;
  logic [15:0]        p_sample;

  logic out_free;
  logic load;

  assign out_free = !m_tvalid || m_tready;
  assign load     = p_valid && out_free;
  assign s_tready = !p_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (s_tready) begin
      p_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      p_req    <= s_tuser;
      p_value  <= s_tdata[31:0];
      p_sample <= s_tdata[47:32];
    end
  end

  // ---------------------------------------------------------------------------
  // Neuron state and update
  // ---------------------------------------------------------------------------
  logic signed [31:0] membrane_level, membrane_level_next;
  logic signed [31:0] syn_sum, syn_sum_next;
  clamp_mode_t        clamp_mode, clamp_mode_next;
  logic               spike_next;

  // membrane + bias + current, saturated
  logic signed [33:0] tick_wide;
  logic signed [31:0] tick_sat;
  assign tick_wide = {{2{membrane_level[31]}}, membrane_level}
                   + {{2{bias[31]}}, bias}
                   + {{2{syn_sum[31]}}, syn_sum};
  always_comb begin
    if (tick_wide[33:31] == 3'b000 || tick_wide[33:31] == 3'b111) begin
      tick_sat = tick_wide[31:0];
    end else if (tick_wide[33]) begin
      tick_sat = S32_MIN;
    end else begin
      tick_sat = S32_MAX;
    end
  end

  // synaptic accumulate, saturated
  logic signed [32:0] add_wide;
  logic signed [31:0] add_sat;
  assign add_wide = {syn_sum[31], syn_sum} + {p_value[31], p_value};
  always_comb begin
    if (add_wide[32] == add_wide[31]) begin
      add_sat = add_wide[31:0];
    end else if (add_wide[32]) begin
      add_sat = S32_MIN;
    end else begin
      add_sat = S32_MAX;
    end
  end

  // decay: tick_sat * (1 - leak), truncated toward zero; magnitude never grows
  logic [16:0]        leak_sat;
  logic [16:0]        keep;
  logic signed [49:0] prod;
  logic signed [49:0] prod_adj;
  logic signed [31:0] decayed;
  assign leak_sat = (leak_fraction > Q_ONE) ? Q_ONE : leak_fraction;
  assign keep     = Q_ONE - leak_sat;
  assign prod     = 50'(tick_sat) * 50'($signed({1'b0, keep}));
  assign prod_adj = prod + (prod[49] ? 50'sd65535 : 50'sd0);
  assign decayed  = prod_adj[47:16];

  logic fire;
  assign fire = (tick_sat > threshold) && (spike_probability >= {1'b0, p_sample});

  always_comb begin
    membrane_level_next = membrane_level;
    syn_sum_next        = syn_sum;
    clamp_mode_next     = clamp_mode;
    spike_next          = 1'b0;
    case (p_req)
      REQ_TICK: begin
        syn_sum_next = '0;
        if (clamp_mode == CLAMP_POS) begin
          membrane_level_next = reset_level;
          clamp_mode_next     = CLAMP_NONE;
          spike_next          = 1'b1;
        end else if (clamp_mode == CLAMP_NONE) begin
          if (fire) begin
            membrane_level_next = reset_level;
            spike_next          = 1'b1;
          end else begin
            membrane_level_next = decayed;
          end
        end else begin
          membrane_level_next = reset_level;
        end
      end
      REQ_ADD: begin
        syn_sum_next = add_sat;
      end
      REQ_CLAMP: begin
        if (p_value > 0) begin
          clamp_mode_next = CLAMP_POS;
        end else if (p_value < 0) begin
          clamp_mode_next = CLAMP_NEG;
        end else begin
          clamp_mode_next = CLAMP_NONE;
        end
      end
      default: begin  // model reset
        membrane_level_next = reset_level;
        syn_sum_next        = '0;
        clamp_mode_next     = CLAMP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      membrane_level <= '0;
      syn_sum        <= '0;
      clamp_mode     <= CLAMP_NONE;
    end else if (load) begin
      membrane_level <= membrane_level_next;
      syn_sum        <= syn_sum_next;
      clamp_mode     <= clamp_mode_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic               out_spike;
  logic signed [31:0] out_membrane;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_spike    <= spike_next;
      out_membrane <= membrane_level_next;
    end
  end

  assign m_tdata = {7'd0, out_membrane, out_spike};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_reset_clean: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !p_valid && clamp_mode == CLAMP_NONE && syn_sum == '0))
    else $error("state not cleared after reset");

  a_tick_clears_current: assert property (@(posedge clk) disable iff (rst)
    (load && p_req == REQ_TICK) |=> (syn_sum == '0))
    else $error("synaptic sum not cleared by tick");

  a_nontick_no_spike: assert property (@(posedge clk) disable iff (rst)
    (load && p_req != REQ_TICK) |=> (m_tvalid && !out_spike))
    else $error("spike on a non-tick word");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    load |=> (out_membrane == membrane_level))
    else $error("result membrane differs from state");

endmodule

// File: verif/tb_stochastic_lif_neuron_core.sv
// Self-checking testbench for the stochastic LIF neuron core.
`timescale 1ns / 1ps

module tb_stochastic_lif_neuron_core;
  import slif_pkg::*;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;    // [31:0] value, [47:32] random_sample
  logic [1:0]  s_tuser  = REQ_TICK; // [1:0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;          // [0] spike, [32:1] membrane, [39:33] zero
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [4:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  stochastic_lif_neuron_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // ---------------------------------------------------------------------------
  // Neuron predictor: own copy of the registers and of the neuron state.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic              spike;
    logic signed [31:0] membrane;
  } neuron_out_t;

  logic signed [31:0] threshold_r;
  logic signed [31:0] reset_lvl_r;
  logic signed [31:0] bias_r;
  logic [16:0]        leak_r;
  logic [16:0]        prob_r;

  logic signed [31:0] membrane_q;
  logic signed [31:0] syn_sum_q;
  clamp_mode_t        clamp_q;

  // Spike/membrane words still owed by the core, oldest first
  neuron_out_t pending_updates [$];

  int errs      = 0;
  int n_words   = 0;
  int n_ticks   = 0;
  int n_spikes  = 0;
  int n_adds    = 0;
  int n_clamps  = 0;
  int n_resets  = 0;
  int n_cfg     = 0;
  bit no_idle   = 1'b0;  // when set, neither side inserts gaps or stalls

  function automatic logic signed [31:0] clip_s32(longint v);
    if (v > longint'(S32_MAX)) return S32_MAX;
    if (v < longint'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

  // Applies one request to the predicted state and returns the expected word.
  function automatic neuron_out_t advance_neuron(logic [1:0] req, logic signed [31:0] val,
                                                 logic [15:0] sample);
    neuron_out_t res;
    longint      prod;
    logic [16:0] lk;
    res.spike = 1'b0;
    case (req)
      REQ_TICK: begin
        membrane_q = clip_s32(longint'(membrane_q) + longint'(bias_r) + longint'(syn_sum_q));
        syn_sum_q  = '0;
        if (clamp_q == CLAMP_POS) begin
          // forced spike, clamp is one-shot
          membrane_q = reset_lvl_r;
          clamp_q    = CLAMP_NONE;
          res.spike  = 1'b1;
        end else if (clamp_q == CLAMP_NEG) begin
          membrane_q = reset_lvl_r;
        end else if (membrane_q > threshold_r && prob_r >= {1'b0, sample}) begin
          membrane_q = reset_lvl_r;
          res.spike  = 1'b1;
        end else begin
          // leak saturates at 1.0; product truncates toward zero
          lk         = (leak_r > Q_ONE) ? Q_ONE : leak_r;
          prod       = longint'(membrane_q) * longint'(Q_ONE - lk);
          membrane_q = clip_s32(prod / 65536);
        end
      end
      REQ_ADD: syn_sum_q = clip_s32(longint'(syn_sum_q) + longint'(val));
      REQ_CLAMP: begin
        if (val > 0)      clamp_q = CLAMP_POS;
        else if (val < 0) clamp_q = CLAMP_NEG;
        else              clamp_q = CLAMP_NONE;
      end
      default: begin
        membrane_q = reset_lvl_r;
        syn_sum_q  = '0;
        clamp_q    = CLAMP_NONE;
      end
    endcase
    res.membrane = membrane_q;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall per word, compare against the oldest expectation.
  // m_tready is decided once per edge, so a stall count drawn right after an
  // accept lands the gap on whatever phase the core happens to be in.
  // ---------------------------------------------------------------------------
  int rx_wait;

  always @(posedge clk) begin : result_side
    neuron_out_t got;
    neuron_out_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = $urandom_range(0, 3);
    end else begin
      if (m_tvalid && m_tready) begin
        got.spike    = m_tdata[0];
        got.membrane = m_tdata[32:1];
        if (pending_updates.size() == 0) begin
          $error("unexpected result word: spike %0d membrane %h", got.spike, got.membrane);
          errs++;
        end else begin
          want = pending_updates.pop_front();
          if (got.spike !== want.spike) begin
            $error("spike: expected %0d, got %0d", want.spike, got.spike);
            errs++;
          end
          if (got.membrane !== want.membrane) begin
            $error("membrane: expected %h, got %h", want.membrane, got.membrane);
            errs++;
          end
        end
        rx_wait = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (rx_wait > 0) begin
        m_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Sends one word after a random gap; valid stays high between back-to-back
  // words. When use_typed is set the hand-written result is expected instead
  // of the predicted one (the predictor still advances).
  task automatic send_word(logic [1:0] req, logic [31:0] val, logic [15:0] sample,
                           bit use_typed, neuron_out_t typed);
    int          gap;
    neuron_out_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {sample, val};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = advance_neuron(req, val, sample);
    pending_updates = {pending_updates, (use_typed ? typed : pred)};
    n_words++;
    case (req)
      REQ_TICK: begin
        n_ticks++;
        if (pred.spike) n_spikes++;
      end
      REQ_ADD:   n_adds++;
      REQ_CLAMP: n_clamps++;
      default:   n_resets++;
    endcase
  endtask

  // APB write (setup + access) followed by a read-back of the same register.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register taken at this edge; turn straight into the read setup
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_THRESHOLD:   threshold_r = data;
      REG_RESET_LEVEL: reset_lvl_r = data;
      REG_BIAS:        bias_r      = data;
      REG_LEAK:        leak_r      = data[16:0];
      default:         prob_r      = data[16:0];
    endcase
    want = (idx == REG_LEAK || idx == REG_SPIKE_PROB) ? {15'b0, data[16:0]} : data;
    if (prdata !== want) begin
      $error("prdata reg %0d: expected %h, got %h", idx, want, prdata);
      errs++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    n_cfg++;
  endtask

  // Every request yields a word, so an empty queue means the core is idle;
  // the extra cycles cover the two-stage pipe.
  task automatic wait_drained();
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Directed rows, run with the reset register values
  // (threshold 1.0, reset level 0, bias 0, no leak, probability 1.0).
  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] val;
    logic [15:0] smp;
    bit          typed;
    logic        spk;
    logic [31:0] mem;
  } dir_row_t;

  localparam int N_DIR = 25;
  dir_row_t dir_rows [0:N_DIR-1] = '{
    '{REQ_TICK,  32'h0000_0000, 16'h0000, 1'b1, 1'b0, 32'h0000_0000}, // idle tick after reset
    '{REQ_ADD,   32'h7fff_ffff, 16'h0000, 1'b1, 1'b0, 32'h0000_0000},
    '{REQ_ADD,   32'h7fff_ffff, 16'hffff, 1'b1, 1'b0, 32'h0000_0000}, // current saturates high
    '{REQ_TICK,  32'h0000_0000, 16'hffff, 1'b1, 1'b1, 32'h0000_0000}, // full prob beats max sample
    '{REQ_ADD,   32'h8000_0000, 16'h0000, 1'b1, 1'b0, 32'h0000_0000},
    '{REQ_ADD,   32'h8000_0000, 16'h0000, 1'b1, 1'b0, 32'h0000_0000}, // current saturates low
    '{REQ_TICK,  32'h0000_0000, 16'h0000, 1'b1, 1'b0, 32'h8000_0000},
    '{REQ_CLAMP, 32'h0000_0001, 16'h0000, 1'b1, 1'b0, 32'h8000_0000}, // positive clamp
    '{REQ_TICK,  32'h0000_0000, 16'h0000, 1'b1, 1'b1, 32'h0000_0000}, // forced spike
    '{REQ_CLAMP, 32'h8000_0000, 16'h0000, 1'b1, 1'b0, 32'h0000_0000}, // negative clamp
    '{REQ_ADD,   32'h0005_0000, 16'h0000, 1'b1, 1'b0, 32'h0000_0000},
    '{REQ_TICK,  32'h0000_0000, 16'h0000, 1'b1, 1'b0, 32'h0000_0000}, // held at reset level
    '{REQ_TICK,  32'h0000_0000, 16'hffff, 1'b0, 1'b0, 32'h0000_0000}, // clamp still holds
    '{REQ_CLAMP, 32'h0000_0000, 16'h0000, 1'b1, 1'b0, 32'h0000_0000}, // zero clears clamp
    '{REQ_ADD,   32'h0002_0000, 16'h0000, 1'b1, 1'b0, 32'h0000_0000},
    '{REQ_TICK,  32'h0000_0000, 16'h0000, 1'b1, 1'b1, 32'h0000_0000},
    '{REQ_RESET, 32'hffff_ffff, 16'hffff, 1'b1, 1'b0, 32'h0000_0000},
    '{REQ_ADD,   32'h0001_0000, 16'h0000, 1'b1, 1'b0, 32'h0000_0000},
    '{REQ_TICK,  32'h0000_0000, 16'h0000, 1'b1, 1'b0, 32'h0001_0000}, // equal to threshold: no spike
    '{REQ_ADD,   32'h7fff_ffff, 16'h0000, 1'b1, 1'b0, 32'h0001_0000},
    '{REQ_TICK,  32'h0000_0000, 16'h8000, 1'b1, 1'b1, 32'h0000_0000}, // tick sum saturates
    '{REQ_CLAMP, 32'h7fff_ffff, 16'h0000, 1'b1, 1'b0, 32'h0000_0000},
    '{REQ_RESET, 32'h0000_0000, 16'h0000, 1'b1, 1'b0, 32'h0000_0000}, // model reset drops clamp
    '{REQ_TICK,  32'h0000_0000, 16'h0000, 1'b1, 1'b0, 32'h0000_0000},
    '{REQ_CLAMP, 32'hffff_ffff, 16'h0000, 1'b0, 1'b0, 32'h0000_0000}
  };

  // Fixed register sets: threshold, reset level, bias, leak, probability.
  // Includes both ends of every register and leak/probability above one.
  localparam int N_FIXED = 4;
  logic [31:0] fixed_cfg [0:N_FIXED-1][0:4] = '{
    '{32'h0002_0000, 32'hffff_0000, 32'h0000_1000, 32'h0000_4000, 32'h0000_8000},
    '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_ffff, 32'h0001_ffff},
    '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000},
    '{32'h0000_0000, 32'h0000_0000, 32'hffff_c000, 32'h0001_0000, 32'h0001_0000}
  };

  localparam int N_PHASES        = 6;
  localparam int WORDS_PER_PHASE = 150;

  // One random request. Mostly ticks and small currents so the membrane
  // actually travels across the threshold; some full-range values and
  // extremes drive saturation.
  task automatic send_random_word();
    int          pick;
    logic [1:0]  req;
    logic [31:0] r;
    logic [31:0] val;
    logic [15:0] smp;
    neuron_out_t none;
    none = '0;
    pick = $urandom_range(0, 99);
    if (pick < 45)      req = REQ_TICK;
    else if (pick < 80) req = REQ_ADD;
    else if (pick < 94) req = REQ_CLAMP;
    else                req = REQ_RESET;
    r = $urandom;
    case ($urandom_range(0, 5))
      0, 1:    val = {{14{r[17]}}, r[17:0]};   // about +/-2.0
      2:       val = {{16{r[15]}}, r[15:0]};   // about +/-0.5
      3:       val = r;
      4:       val = r[0] ? S32_MAX : S32_MIN;
      default: val = '0;
    endcase
    case ($urandom_range(0, 7))
      0:       smp = 16'h0000;
      1:       smp = 16'hffff;
      default: smp = 16'($urandom_range(0, 65535));
    endcase
    send_word(req, val, smp, 1'b0, none);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    neuron_out_t typed;
    logic [31:0] r;
    threshold_r = THRESHOLD_RST;
    reset_lvl_r = '0;
    bias_r      = '0;
    leak_r      = '0;
    prob_r      = Q_ONE;
    membrane_q  = '0;
    syn_sum_q   = '0;
    clamp_q     = CLAMP_NONE;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table with reset register values
    for (int i = 0; i < N_DIR; i++) begin
      typed.spike    = dir_rows[i].spk;
      typed.membrane = dir_rows[i].mem;
      send_word(dir_rows[i].req, dir_rows[i].val, dir_rows[i].smp, dir_rows[i].typed, typed);
    end
    s_tvalid <= 1'b0;
    wait_drained();

    // random phases, each under its own register set
    for (int p = 0; p < N_PHASES; p++) begin
      if (p < N_FIXED) begin
        write_reg(REG_THRESHOLD,   fixed_cfg[p][0]);
        write_reg(REG_RESET_LEVEL, fixed_cfg[p][1]);
        write_reg(REG_BIAS,        fixed_cfg[p][2]);
        write_reg(REG_LEAK,        fixed_cfg[p][3]);
        write_reg(REG_SPIKE_PROB,  fixed_cfg[p][4]);
      end else begin
        r = $urandom;
        write_reg(REG_THRESHOLD,   {{13{r[18]}}, r[18:0]});
        r = $urandom;
        write_reg(REG_RESET_LEVEL, {{15{r[16]}}, r[16:0]});
        r = $urandom;
        write_reg(REG_BIAS,        {{16{r[15]}}, r[15:0]});
        write_reg(REG_LEAK,        $urandom_range(0, 32'h0001_2000));
        write_reg(REG_SPIKE_PROB,  $urandom_range(0, 32'h0001_0000));
      end
      @(posedge clk);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        // stretches of full-rate traffic now and then
        if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_random_word();
      end
      s_tvalid <= 1'b0;
      no_idle = 1'b0;
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (pending_updates.size() != 0) begin
      $error("%0d result words never arrived", pending_updates.size());
      errs++;
    end
    $display("Sent %0d words: %0d ticks (%0d spikes), %0d adds, %0d clamps, %0d model resets",
             n_words, n_ticks, n_spikes, n_adds, n_clamps, n_resets);
    $display("Register writes: %0d over %0d register sets", n_cfg, N_PHASES);
    if (errs == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("Timeout with %0d result words outstanding", pending_updates.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
